[hdl/qau_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Shared types, operation codes, product tables and the saturation function.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int NUM_W     = 50;
  localparam int DEN_W     = 50;
  localparam int NSQ_W     = 49;
  localparam int NORM_W    = 33;
  localparam int QUO_W     = 33;
  localparam int SQ_STEPS  = 32;
  localparam int SQ_LAT    = SQ_STEPS + 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int FRAC      = 16;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_SCALE = 4'd3,
    CMD_ADDS  = 4'd4,
    CMD_CONJ  = 4'd5,
    CMD_NORM  = 4'd6,
    CMD_NRM   = 4'd7,
    CMD_DIVS  = 4'd8,
    CMD_DIV   = 4'd9
  } cmd_e;

  // Hamilton product terms: component c, term t uses a[A_IDX] * b[B_IDX].
  localparam logic [1:0] A_IDX [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd0, 2'd3, 2'd1, 2'd2}
  };
  localparam logic [1:0] B_IDX [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd2, 2'd1}
  };
  localparam logic [3:0] H_NEG [4] = '{4'b1110, 4'b1000, 4'b1000, 4'b1000};

  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;

  typedef struct packed {
    logic [3:0]        cmd;
    logic signed [31:0] a_real;
    logic signed [31:0] a_i;
    logic signed [31:0] a_j;
    logic signed [31:0] a_k;
    logic signed [31:0] b_real;
    logic signed [31:0] b_i;
    logic signed [31:0] b_j;
    logic signed [31:0] b_k;
  } in_t;

  typedef struct packed {
    logic signed [31:0] r_real;
    logic signed [31:0] r_i;
    logic signed [31:0] r_j;
    logic signed [31:0] r_k;
    logic               div_zero;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic [3:0]        cmd;
    num_t [3:0]        num;
    den_t [3:0]        mag;
    logic [3:0]        nneg;
    logic [31:0]       b0mag;
    logic              b0neg;
    logic [NSQ_W-1:0]  nsq;
  } mid_t;

  typedef struct packed {
    logic [3:0]        cmd;
    logic              dz;
    logic [3:0]        neg;
    logic [NORM_W-1:0] norm;
    num_t [3:0]        num;
  } late_t;

  typedef struct packed {
    logic           big;
    logic [QUO_W:0] q;
  } quo_t;

  function automatic logic [32:0] sat_q(input num_t v);
    logic [32:0] r;
    if ((&v[NUM_W-1:31]) || !(|v[NUM_W-1:31])) begin
      r = {1'b0, v[31:0]};
    end else if (v[NUM_W-1]) begin
      r = {1'b1, Q_MIN};
    end else begin
      r = {1'b1, Q_MAX};
    end
    return r;
  endfunction

endpackage

[hdl/qau_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined square root
// One result bit per stage, then a rounding stage to the nearest integer.
// ----------------------------------------------------------------------------
module qau_sqrt import qau_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [64:0]       x_i,
  output logic [NORM_W-1:0] norm_o
);

  logic [63:0] x_q    [SQ_STEPS];
  logic [33:0] rem_q  [SQ_STEPS];
  logic [31:0] root_q [SQ_STEPS];
  logic        top_q  [SQ_STEPS];
  logic [NORM_W-1:0] norm_q;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_st
    logic [63:0] xs;
    logic [33:0] rs;
    logic [31:0] qs;
    logic        ts;
    logic [35:0] rsh;
    logic [35:0] trial;
    logic [33:0] rem_d;
    logic [31:0] root_d;

    if (k == 0) begin : g_first
      assign xs = x_i[63:0];
      assign rs = '0;
      assign qs = '0;
      assign ts = x_i[64];
    end else begin : g_next
      assign xs = x_q[k-1];
      assign rs = rem_q[k-1];
      assign qs = root_q[k-1];
      assign ts = top_q[k-1];
    end

    always_comb begin
      rsh   = {rs, xs[2*(SQ_STEPS-1-k) +: 2]};
      trial = {2'b00, qs, 2'b01};
      if (rsh >= trial) begin
        rem_d  = 34'(rsh - trial);
        root_d = {qs[30:0], 1'b1};
      end else begin
        rem_d  = rsh[33:0];
        root_d = {qs[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= xs;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        top_q[k]  <= ts;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (top_q[SQ_STEPS-1]) begin
        norm_q <= {1'b1, 32'd0};
      end else begin
        norm_q <= {1'b0, root_q[SQ_STEPS-1]} +
                  NORM_W'(rem_q[SQ_STEPS-1] > {2'b00, root_q[SQ_STEPS-1]});
      end
    end
  end

  assign norm_o = norm_q;

endmodule

[hdl/qau_div.sv]
// ----------------------------------------------------------------------------
// Pipelined divider lane
// Restoring division of n * 2^16 by d, one quotient bit per stage, with an
// early range check and round-half-up at the end.
// ----------------------------------------------------------------------------
module qau_div import qau_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  den_t n_i,
  input  den_t d_i,
  output quo_t quo_o
);

  den_t             n_q   [DIV_STEPS+1];
  den_t             d_q   [DIV_STEPS+1];
  den_t             r_q   [DIV_STEPS+1];
  logic [QUO_W-1:0] q_q   [DIV_STEPS+1];
  logic             big_q [DIV_STEPS+1];
  quo_t             quo_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= n_i;
      d_q[0]   <= d_i;
      r_q[0]   <= n_i >> (FRAC + 1);
      q_q[0]   <= '0;
      big_q[0] <= (n_i >> (FRAC + 1)) >= d_i;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_st
    logic             nb;
    logic [DEN_W:0]   rsh;
    den_t             r_d;
    logic             qb;

    if (QUO_W - 1 - j >= FRAC) begin : g_bit
      assign nb = n_q[j][QUO_W-1-j-FRAC];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    always_comb begin
      rsh = {r_q[j], nb};
      qb  = rsh >= {1'b0, d_q[j]};
      if (qb) begin
        r_d = DEN_W'(rsh - {1'b0, d_q[j]});
      end else begin
        r_d = rsh[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j+1]   <= n_q[j];
        d_q[j+1]   <= d_q[j];
        r_q[j+1]   <= r_d;
        q_q[j+1]   <= {q_q[j][QUO_W-2:0], qb};
        big_q[j+1] <= big_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q.big <= big_q[DIV_STEPS];
      quo_q.q   <= {1'b0, q_q[DIV_STEPS]} +
                   (QUO_W+1)'({r_q[DIV_STEPS], 1'b0} >= {1'b0, d_q[DIV_STEPS]});
    end
  end

  assign quo_o = quo_q;

endmodule

[hdl/quaternion_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Add, subtract, Hamilton product, scale, add scalar, conjugate, norm,
// normalize, divide by scalar and quaternion divide on Q16.16 components.
// ----------------------------------------------------------------------------
// The unit accepts one beat per cycle while in_stall_o is low and returns each
// result in order. Every operation takes the same path, through the square
// root that forms the norm and the divider that follows it. An output register
// with a one-entry skid stage lets the pipeline keep accepting beats while a
// result waits; stall is raised only once the skid stage is full.
module quaternion_arithmetic_unit import qau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  logic en;

  // Stage 1: products, squares and simple results.
  logic signed [31:0] av [4];
  logic signed [31:0] bv [4];
  logic signed [31:0] sqv [4];
  logic signed [63:0] prod_d [4][4];
  logic signed [63:0] sq_d [4];
  logic signed [32:0] simp_d [4];

  logic               vld1_q;
  logic [3:0]         cmd1_q;
  logic signed [63:0] prod1_q [4][4];
  logic [62:0]        sq1_q [4];
  logic signed [32:0] simp1_q [4];
  logic signed [31:0] a1_q [4];
  logic signed [31:0] b01_q;

  always_comb begin
    av = '{in_i.a_real, in_i.a_i, in_i.a_j, in_i.a_k};
    bv = '{in_i.b_real, in_i.b_i, in_i.b_j, in_i.b_k};
    for (int x = 0; x < 4; x++) begin
      sqv[x]  = (in_i.cmd == CMD_DIV) ? bv[x] : av[x];
      sq_d[x] = sqv[x] * sqv[x];
      for (int y = 0; y < 4; y++) begin
        prod_d[x][y] = av[x] * bv[y];
      end
    end
    for (int c = 0; c < 4; c++) begin
      case (in_i.cmd)
        CMD_ADD:  simp_d[c] = 33'(av[c]) + 33'(bv[c]);
        CMD_SUB:  simp_d[c] = 33'(av[c]) - 33'(bv[c]);
        CMD_ADDS: simp_d[c] = (c == 0) ? 33'(av[c]) + 33'(bv[c]) : 33'(av[c]);
        CMD_CONJ: simp_d[c] = (c == 0) ? 33'(av[c]) : -33'(av[c]);
        default:  simp_d[c] = '0;
      endcase
    end
  end

  // Stage 2: signed pair sums of the product terms and of the squares.
  logic signed [66:0] tm [4][4];
  logic signed [66:0] pr_d [4][2];
  logic               use_t;
  logic               neg_t;

  logic               vld2_q;
  logic [3:0]         cmd2_q;
  logic signed [66:0] pr2_q [4][2];
  logic [63:0]        sqp2_q [2];
  logic signed [32:0] simp2_q [4];
  logic signed [31:0] a2_q [4];
  logic signed [31:0] b02_q;

  always_comb begin
    use_t = 1'b0;
    neg_t = 1'b0;
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        use_t = (cmd1_q == CMD_MUL) || (cmd1_q == CMD_DIV) ||
                ((cmd1_q == CMD_SCALE) && (B_IDX[c][t] == 2'd0));
        neg_t = H_NEG[c][t] ^ ((cmd1_q == CMD_DIV) && (B_IDX[c][t] != 2'd0));
        tm[c][t] = 67'(prod1_q[A_IDX[c][t]][B_IDX[c][t]]);
        if (!use_t) begin
          tm[c][t] = '0;
        end else if (neg_t) begin
          tm[c][t] = -tm[c][t];
        end
      end
      pr_d[c][0] = tm[c][0] + tm[c][1];
      pr_d[c][1] = tm[c][2] + tm[c][3];
    end
  end

  // Stage 3: rounded Hamilton sums and the exact sum of squares.
  logic signed [66:0] hs [4];
  num_t               hv_d [4];

  logic               vld3_q;
  logic [3:0]         cmd3_q;
  num_t               hv3_q [4];
  logic [64:0]        ssum3_q;
  logic signed [32:0] simp3_q [4];
  logic signed [31:0] a3_q [4];
  logic signed [31:0] b03_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hs[c]   = pr2_q[c][0] + pr2_q[c][1] + 67'sd32768;
      hv_d[c] = hs[c][NUM_W+FRAC-1:FRAC];
    end
  end

  // Stage 4 onward: operands for the divider, delayed alongside the root.
  mid_t        mid_d;
  logic [64:0] nsq_sum;
  mid_t        mid_q  [SQ_LAT];
  logic        mvld_q [SQ_LAT];
  logic [NORM_W-1:0] norm;

  always_comb begin
    mid_d     = '0;
    mid_d.cmd = cmd3_q;
    for (int c = 0; c < 4; c++) begin
      case (cmd3_q)
        CMD_ADD, CMD_SUB, CMD_ADDS, CMD_CONJ: mid_d.num[c] = NUM_W'(simp3_q[c]);
        CMD_MUL, CMD_SCALE, CMD_DIV:          mid_d.num[c] = hv3_q[c];
        CMD_NRM, CMD_DIVS:                    mid_d.num[c] = NUM_W'(a3_q[c]);
        default:                              mid_d.num[c] = '0;
      endcase
      mid_d.nneg[c] = mid_d.num[c][NUM_W-1];
      mid_d.mag[c]  = mid_d.nneg[c] ? den_t'(-$signed(mid_d.num[c])) : den_t'(mid_d.num[c]);
    end
    mid_d.b0neg = b03_q[31];
    mid_d.b0mag = b03_q[31] ? 32'(-b03_q) : 32'(b03_q);
    nsq_sum     = ssum3_q + 65'd32768;
    mid_d.nsq   = nsq_sum[64:FRAC];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en) begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q  <= in_i.cmd;
      prod1_q <= prod_d;
      for (int x = 0; x < 4; x++) begin
        sq1_q[x] <= sq_d[x][62:0];
      end
      simp1_q <= simp_d;
      a1_q    <= av;
      b01_q   <= in_i.b_real;

      cmd2_q    <= cmd1_q;
      pr2_q     <= pr_d;
      sqp2_q[0] <= {1'b0, sq1_q[0]} + {1'b0, sq1_q[1]};
      sqp2_q[1] <= {1'b0, sq1_q[2]} + {1'b0, sq1_q[3]};
      simp2_q   <= simp1_q;
      a2_q      <= a1_q;
      b02_q     <= b01_q;

      cmd3_q  <= cmd2_q;
      hv3_q   <= hv_d;
      ssum3_q <= {1'b0, sqp2_q[0]} + {1'b0, sqp2_q[1]};
      simp3_q <= simp2_q;
      a3_q    <= a2_q;
      b03_q   <= b02_q;
    end
  end

  for (genvar s = 0; s < SQ_LAT; s++) begin : g_mid
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          mvld_q[s] <= 1'b0;
        end else if (en) begin
          mvld_q[s] <= vld3_q;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          mid_q[s] <= mid_d;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          mvld_q[s] <= 1'b0;
        end else if (en) begin
          mvld_q[s] <= mvld_q[s-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          mid_q[s] <= mid_q[s-1];
        end
      end
    end
  end

  qau_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (ssum3_q),
    .norm_o (norm)
  );

  // Divisor selection and the divider lanes.
  mid_t  m;
  den_t  dvs;
  late_t late_d;
  quo_t  quo [4];
  late_t late_q [DIV_LAT];
  logic  lvld_q [DIV_LAT];

  always_comb begin
    m = mid_q[SQ_LAT-1];
    case (m.cmd)
      CMD_NRM:  dvs = DEN_W'(norm);
      CMD_DIVS: dvs = DEN_W'(m.b0mag);
      default:  dvs = DEN_W'(m.nsq);
    endcase
    late_d      = '0;
    late_d.cmd  = m.cmd;
    late_d.dz   = ((m.cmd == CMD_NRM) || (m.cmd == CMD_DIVS) || (m.cmd == CMD_DIV)) &&
                  (dvs == '0);
    late_d.norm = norm;
    late_d.num  = m.num;
    for (int c = 0; c < 4; c++) begin
      late_d.neg[c] = m.nneg[c] ^ ((m.cmd == CMD_DIVS) && m.b0neg);
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    qau_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .n_i   (m.mag[c]),
      .d_i   (dvs),
      .quo_o (quo[c])
    );
  end

  for (genvar s = 0; s < DIV_LAT; s++) begin : g_late
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          lvld_q[s] <= 1'b0;
        end else if (en) begin
          lvld_q[s] <= mvld_q[SQ_LAT-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          late_q[s] <= late_d;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          lvld_q[s] <= 1'b0;
        end else if (en) begin
          lvld_q[s] <= lvld_q[s-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          late_q[s] <= late_q[s-1];
        end
      end
    end
  end

  // Final selection and saturation.
  late_t       l;
  num_t        v [4];
  num_t        qs;
  logic [32:0] sv [4];
  out_t        res;
  logic        p_vld;

  always_comb begin
    l  = late_q[DIV_LAT-1];
    qs = '0;
    for (int c = 0; c < 4; c++) begin
      case (l.cmd)
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_SCALE, CMD_ADDS, CMD_CONJ: begin
          v[c] = l.num[c];
        end
        CMD_NORM: begin
          v[c] = (c == 0) ? NUM_W'(l.norm) : '0;
        end
        CMD_NRM, CMD_DIVS, CMD_DIV: begin
          if (l.dz) begin
            v[c] = '0;
          end else if (quo[c].big) begin
            v[c] = l.neg[c] ? {1'b1, {(NUM_W-1){1'b0}}} : {1'b0, {(NUM_W-1){1'b1}}};
          end else begin
            qs   = NUM_W'(quo[c].q);
            v[c] = l.neg[c] ? -qs : qs;
          end
        end
        default: begin
          v[c] = '0;
        end
      endcase
      sv[c] = sat_q(v[c]);
    end
    res.r_real   = sv[0][31:0];
    res.r_i      = sv[1][31:0];
    res.r_j      = sv[2][31:0];
    res.r_k      = sv[3][31:0];
    res.div_zero = l.dz;
    res.overflow = sv[0][32] | sv[1][32] | sv[2][32] | sv[3][32];
    p_vld        = lvld_q[DIV_LAT-1];
  end

  // Output register and skid stage.
  logic out_vld_q;
  logic skid_vld_q;
  out_t out_q;
  out_t skid_q;

  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || !out_stall_i) begin
      out_vld_q  <= skid_vld_q || p_vld;
      skid_vld_q <= 1'b0;
    end else if (en && p_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || !out_stall_i) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (en && p_vld) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

[hdl/qau_checker.sv]
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit checker
// Port-level assertions on the result channel and the skid behavior.
// ----------------------------------------------------------------------------
module qau_checker import qau_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result beat changed");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.div_zero |->
      out_o.r_real == 32'sd0 && out_o.r_i == 32'sd0 && out_o.r_j == 32'sd0 &&
      out_o.r_k == 32'sd0 && !out_o.overflow)
    else $error("division by zero result is not clean zero");

  a_ovf_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.overflow |->
      out_o.r_real == Q_MAX || out_o.r_real == Q_MIN || out_o.r_i == Q_MAX ||
      out_o.r_i == Q_MIN || out_o.r_j == Q_MAX || out_o.r_j == Q_MIN ||
      out_o.r_k == Q_MAX || out_o.r_k == Q_MIN)
    else $error("overflow without a saturated component");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i) && out_valid_o)
    else $error("input stall without a held result");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (.*);
